>>> hdl/lrsm_pkg.sv
// Shared types and constants for the longest reversed segment match block.
// Used by lrsm_cell and longest_reversed_segment_match; depends on nothing.

package lrsm_pkg;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned TDATA_W = 16;

  typedef struct packed {
    logic clear;
    logic shift;
    logic sweep;
    logic reduce;
  } cell_ctrl_t;

endpackage

>>> hdl/lrsm_cell.sv
// One cell of the match row: holds one stored element, the run length of the
// diagonal passing through it and the best run seen. Depends on lrsm_pkg.

module lrsm_cell #(
  parameter int unsigned RUN_W = 11
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lrsm_pkg::cell_ctrl_t             ctrl,
  input  logic [lrsm_pkg::DATA_W-1:0]      bcast,
  input  logic [lrsm_pkg::DATA_W-1:0]      data_in,
  input  logic                             vld_in,
  input  logic [RUN_W-1:0]                 run_in,
  input  logic [RUN_W-1:0]                 best_in,
  output logic [lrsm_pkg::DATA_W-1:0]      data_o,
  output logic                             vld_o,
  output logic [RUN_W-1:0]                 run_o,
  output logic [RUN_W-1:0]                 best_o
);

  logic [lrsm_pkg::DATA_W-1:0] data_r;
  logic                        vld_r;
  logic [RUN_W-1:0]            run_r;
  logic [RUN_W-1:0]            best_r;
  logic [RUN_W-1:0]            run_nxt;
  logic [RUN_W-1:0]            best_nxt;
  logic [RUN_W-1:0]            cand;

  // A match extends the run handed over by the left neighbor on the same diagonal.
  always_comb begin
    if (vld_r && (data_r == bcast)) begin
      cand = run_in + RUN_W'(1);
    end else begin
      cand = '0;
    end
  end

  always_comb begin
    run_nxt  = run_r;
    best_nxt = best_r;
    priority if (ctrl.clear) begin
      run_nxt  = '0;
      best_nxt = '0;
    end else if (ctrl.sweep) begin
      run_nxt  = cand;
      best_nxt = (cand > best_r) ? cand : best_r;
    end else if (ctrl.reduce) begin
      best_nxt = (best_in > best_r) ? best_in : best_r;
    end else begin
      run_nxt  = run_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      run_r  <= '0;
      best_r <= '0;
    end else begin
      run_r  <= run_nxt;
      best_r <= best_nxt;
      if (ctrl.clear) begin
        vld_r <= 1'b0;
      end else if (ctrl.shift) begin
        vld_r <= vld_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data_r <= data_in;
    end
  end

  assign data_o = data_r;
  assign vld_o  = vld_r;
  assign run_o  = run_r;
  assign best_o = best_r;

endmodule

>>> hdl/longest_reversed_segment_match.sv
// Top level of the longest reversed segment match block: element store,
// sequencing and the row of lrsm_cell instances. Depends on lrsm_pkg and lrsm_cell.
//
// Channel | Direction | Ports                          | Contents
// in_     | slave     | in_tvalid/tready/tdata/tlast   | tdata[15:0] value, tlast last
// out_    | master    | out_tvalid/tready/tdata/tuser  | tdata[10:0] longest_length, tuser overflow
//
// Elements of a sequence are taken one per cycle while in_tready is high, and up to
// MAX_ELEMENTS of them shift into the cell row; later ones set the overflow flag.
// After the last element the store is read back one element per cycle, then the
// per-cell maxima are passed along the row to the last cell before the result is
// shown. in_tready is low from the last transfer until the result is shown.
// Reset is synchronous and active low; a result that is still waiting holds back
// the next one, and in_tready stays low until the waiting result leaves.

module longest_reversed_segment_match #(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lrsm_pkg::TDATA_W-1:0]     in_tdata,   // [15:0] value
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lrsm_pkg::TDATA_W-1:0]     out_tdata,  // [10:0] longest_length
  output logic                             out_tuser   // [0] overflow
);

  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned RW = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [2:0] {
    ST_LOAD   = 3'b001,
    ST_SWEEP  = 3'b010,
    ST_REDUCE = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic                            ovf_r, ovf_nxt;
  logic [CW-1:0]                   rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]                   red_cnt_r, red_cnt_nxt;
  logic                            rd_vld_r;
  logic [lrsm_pkg::DATA_W-1:0]     rd_data_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [lrsm_pkg::LEN_W-1:0]      out_len_r;
  logic                            out_ovf_r;
  logic [lrsm_pkg::DATA_W-1:0]     mem [MAX_ELEMENTS];

  logic                            acc;
  logic                            room;
  logic                            done;
  logic                            finish;
  logic [RW+lrsm_pkg::LEN_W-1:0]   best_ext;
  lrsm_pkg::cell_ctrl_t            ctrl;

  logic [lrsm_pkg::DATA_W-1:0]     cell_data [MAX_ELEMENTS];
  logic                            cell_vld  [MAX_ELEMENTS];
  logic [RW-1:0]                   cell_run  [MAX_ELEMENTS];
  logic [RW-1:0]                   cell_best [MAX_ELEMENTS];

  assign in_tready = (state_r == ST_LOAD);
  assign acc       = in_tvalid & in_tready;
  assign room      = (count_r != CW'(MAX_ELEMENTS));
  assign done      = (state_r == ST_REDUCE) && !rd_vld_r &&
                     (red_cnt_r == AW'(MAX_ELEMENTS - 1));
  assign finish    = done && !out_valid_r;

  assign ctrl.clear  = finish;
  assign ctrl.shift  = acc && room;
  assign ctrl.sweep  = rd_vld_r;
  assign ctrl.reduce = (state_r == ST_REDUCE) && !rd_vld_r &&
                       (red_cnt_r != AW'(MAX_ELEMENTS - 1));

  assign best_ext = (RW + lrsm_pkg::LEN_W)'(cell_best[MAX_ELEMENTS-1]);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    rd_idx_nxt    = rd_idx_r;
    red_cnt_nxt   = red_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_LOAD: begin
        if (acc) begin
          if (room) begin
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            state_nxt  = ST_SWEEP;
            rd_idx_nxt = '0;
          end
        end
      end
      ST_SWEEP: begin
        rd_idx_nxt = rd_idx_r + CW'(1);
        if (rd_idx_r == count_r - CW'(1)) begin
          state_nxt   = ST_REDUCE;
          red_cnt_nxt = '0;
        end
      end
      ST_REDUCE: begin
        if (ctrl.reduce) begin
          red_cnt_nxt = red_cnt_r + AW'(1);
        end
        if (finish) begin
          state_nxt     = ST_LOAD;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      rd_idx_r    <= '0;
      red_cnt_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      rd_idx_r    <= rd_idx_nxt;
      red_cnt_r   <= red_cnt_nxt;
      rd_vld_r    <= (state_r == ST_SWEEP);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && room) begin
      mem[count_r[AW-1:0]] <= in_tdata[lrsm_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_len_r <= best_ext[lrsm_pkg::LEN_W-1:0];
      out_ovf_r <= ovf_r;
    end
  end

  genvar k;
  generate
    for (k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
      if (k == 0) begin : g_first
        lrsm_cell #(.RUN_W(RW)) u_cell (
          .clk     (clk),
          .rst_n   (rst_n),
          .ctrl    (ctrl),
          .bcast   (rd_data_r),
          .data_in (in_tdata[lrsm_pkg::DATA_W-1:0]),
          .vld_in  (1'b1),
          .run_in  ({RW{1'b0}}),
          .best_in ({RW{1'b0}}),
          .data_o  (cell_data[k]),
          .vld_o   (cell_vld[k]),
          .run_o   (cell_run[k]),
          .best_o  (cell_best[k])
        );
      end else begin : g_next
        lrsm_cell #(.RUN_W(RW)) u_cell (
          .clk     (clk),
          .rst_n   (rst_n),
          .ctrl    (ctrl),
          .bcast   (rd_data_r),
          .data_in (cell_data[k-1]),
          .vld_in  (cell_vld[k-1]),
          .run_in  (cell_run[k-1]),
          .best_in (cell_best[k-1]),
          .data_o  (cell_data[k]),
          .vld_o   (cell_vld[k]),
          .run_o   (cell_run[k]),
          .best_o  (cell_best[k])
        );
      end
    end
  endgenerate

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(lrsm_pkg::TDATA_W - lrsm_pkg::LEN_W){1'b0}}, out_len_r};
  assign out_tuser  = out_ovf_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ELEMENTS))
    else $error("element count exceeds the store depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (count_r == CW'(MAX_ELEMENTS)))
    else $error("overflow flagged while the store still has room");

  a_ctrl_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.shift && (ctrl.sweep || ctrl.reduce)))
    else $error("cell row shifted during the sweep or reduction");

  a_sweep_not_load: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.sweep |-> (state_r != ST_LOAD))
    else $error("sweep step while loading elements");

  a_clear_row: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear |=> !cell_vld[0])
    else $error("cell row not emptied after a result");
`endif

endmodule
